FILE: sv/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared types, constants and the arctangent table for the odometry block.
// ----------------------------------------------------------------------------
package ddo_pkg;

    localparam int SINCOS_STAGES_DEF = 16;
    localparam int ATAN_ENTRIES      = 30;
    localparam int ATAN_IDX_W        = 5;
    localparam int CORDIC_W          = 34;
    localparam int MUL_W             = 33;
    localparam int PROD_W            = 2 * MUL_W;
    localparam int PADDR_W           = 3;

    localparam logic [31:0] METER_PER_TIC_RST = 32'd429497;
    localparam logic [31:0] ROT_PER_TIC_RST   = 32'd0;
    localparam logic signed [CORDIC_W-1:0] CORDIC_START = 34'sd652032874;

    localparam logic OP_STEP = 1'b0;
    localparam logic OP_SET  = 1'b1;

    localparam logic REG_METER_PER_TIC = 1'b0;
    localparam logic REG_ROT_PER_TIC   = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic signed [15:0] left_tics;
        logic signed [15:0] right_tics;
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
        logic signed [31:0] new_theta;
        logic        [2:0]  set_mask;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] dist_res;
        logic signed [31:0] rot;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] heading;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIST,
        ST_ROT,
        ST_INIT,
        ST_ITER,
        ST_MULX,
        ST_MULY,
        ST_COMMIT
    } state_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_MUL_DIST,
        DP_MUL_ROT,
        DP_INIT,
        DP_ITER,
        DP_MUL_X,
        DP_MUL_Y,
        DP_COMMIT,
        DP_SET
    } dp_op_t;

    typedef struct packed {
        dp_op_t                  op;
        logic [ATAN_IDX_W-1:0]   idx;
    } dp_cmd_t;

    typedef struct packed {
        logic out_busy;
    } dp_status_t;

    function automatic logic [31:0] atan_lookup(input logic [ATAN_IDX_W-1:0] i);
        logic [31:0] v;
        begin
            unique case (i)
                5'd0:    v = 32'd536870912;
                5'd1:    v = 32'd316933406;
                5'd2:    v = 32'd167458907;
                5'd3:    v = 32'd85004756;
                5'd4:    v = 32'd42667331;
                5'd5:    v = 32'd21354465;
                5'd6:    v = 32'd10680862;
                5'd7:    v = 32'd5340245;
                5'd8:    v = 32'd2670163;
                5'd9:    v = 32'd1335087;
                5'd10:   v = 32'd667544;
                5'd11:   v = 32'd333772;
                5'd12:   v = 32'd166886;
                5'd13:   v = 32'd83443;
                5'd14:   v = 32'd41722;
                5'd15:   v = 32'd20861;
                5'd16:   v = 32'd10430;
                5'd17:   v = 32'd5215;
                5'd18:   v = 32'd2608;
                5'd19:   v = 32'd1304;
                5'd20:   v = 32'd652;
                5'd21:   v = 32'd326;
                5'd22:   v = 32'd163;
                5'd23:   v = 32'd81;
                5'd24:   v = 32'd41;
                5'd25:   v = 32'd20;
                5'd26:   v = 32'd10;
                5'd27:   v = 32'd5;
                5'd28:   v = 32'd3;
                5'd29:   v = 32'd1;
                default: v = 32'd0;
            endcase
            return v;
        end
    endfunction

endpackage

FILE: sv/ddo_ctrl.sv
// ----------------------------------------------------------------------------
// ddo_ctrl
// Sequencer: takes an item, steps the datapath through the products and the
// CORDIC iterations for a step item, and commits when the output slot is free.
// ----------------------------------------------------------------------------
module ddo_ctrl #(
    parameter int SINCOS_STAGES = ddo_pkg::SINCOS_STAGES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_opcode,
    output logic                 in_ready,
    input  ddo_pkg::dp_status_t  status,
    output ddo_pkg::dp_cmd_t     cmd
);

    localparam int IW = (SINCOS_STAGES > 1) ? $clog2(SINCOS_STAGES) : 1;
    localparam logic [IW-1:0] LAST = IW'(SINCOS_STAGES - 1);

    ddo_pkg::state_t state_reg, state_next;
    logic            set_reg, set_next;
    logic [IW-1:0]   cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ddo_pkg::ST_IDLE;
            set_reg   <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            set_reg   <= set_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        set_next   = set_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        cmd.op     = ddo_pkg::DP_NOP;
        cmd.idx    = ddo_pkg::ATAN_IDX_W'(cnt_reg);
        unique case (state_reg)
            ddo_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op   = ddo_pkg::DP_LOAD;
                    set_next = (in_opcode == ddo_pkg::OP_SET);
                    state_next = (in_opcode == ddo_pkg::OP_SET) ? ddo_pkg::ST_COMMIT
                                                                : ddo_pkg::ST_DIST;
                end
            end
            ddo_pkg::ST_DIST:
            begin
                cmd.op     = ddo_pkg::DP_MUL_DIST;
                state_next = ddo_pkg::ST_ROT;
            end
            ddo_pkg::ST_ROT:
            begin
                cmd.op     = ddo_pkg::DP_MUL_ROT;
                state_next = ddo_pkg::ST_INIT;
            end
            ddo_pkg::ST_INIT:
            begin
                cmd.op     = ddo_pkg::DP_INIT;
                cnt_next   = '0;
                state_next = ddo_pkg::ST_ITER;
            end
            ddo_pkg::ST_ITER:
            begin
                cmd.op   = ddo_pkg::DP_ITER;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    state_next = ddo_pkg::ST_MULX;
                end
            end
            ddo_pkg::ST_MULX:
            begin
                cmd.op     = ddo_pkg::DP_MUL_X;
                state_next = ddo_pkg::ST_MULY;
            end
            ddo_pkg::ST_MULY:
            begin
                cmd.op     = ddo_pkg::DP_MUL_Y;
                state_next = ddo_pkg::ST_COMMIT;
            end
            ddo_pkg::ST_COMMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.op     = set_reg ? ddo_pkg::DP_SET : ddo_pkg::DP_COMMIT;
                    state_next = ddo_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ddo_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/ddo_datapath.sv
// ----------------------------------------------------------------------------
// ddo_datapath
// Pose registers, shared signed multiplier, iterative CORDIC and output slot.
// ----------------------------------------------------------------------------
module ddo_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ddo_pkg::dp_cmd_t     cmd,
    output ddo_pkg::dp_status_t  status,
    input  ddo_pkg::in_item_t    in_item,
    input  logic [31:0]          meter_per_tic,
    input  logic [31:0]          rot_per_tic,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ddo_pkg::out_item_t   out_item
);

    localparam int CW = ddo_pkg::CORDIC_W;
    localparam int MW = ddo_pkg::MUL_W;
    localparam int PW = ddo_pkg::PROD_W;

    ddo_pkg::in_item_t    in_reg;
    ddo_pkg::out_item_t   out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;
    logic signed [PW-1:0] prod_reg;
    logic signed [31:0]   dist_reg, rot_reg, dpx_reg;
    logic signed [CW-1:0] cx_reg, cy_reg, cz_reg;
    logic                 flip_reg;
    logic signed [31:0]   pos_x_reg, pos_y_reg, head_reg;
    logic signed [31:0]   pos_x_next, pos_y_next, head_next;

    logic signed [16:0]   tic_sum, tic_diff;
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] prod_next;
    logic signed [CW-1:0] x_sh, y_sh, atan_v, cos_v, sin_v;
    logic                 flip_init;
    logic signed [CW-1:0] z_init;

    always_comb
    begin
        tic_sum  = 17'(in_reg.left_tics) + 17'(in_reg.right_tics);
        tic_diff = 17'(in_reg.right_tics) - 17'(in_reg.left_tics);
        cos_v    = flip_reg ? -cx_reg : cx_reg;
        sin_v    = flip_reg ? -cy_reg : cy_reg;
        mul_a    = MW'(dist_reg);
        mul_b    = cos_v[MW-1:0];
        case (cmd.op)
            ddo_pkg::DP_MUL_DIST:
            begin
                mul_a = MW'(tic_sum);
                mul_b = signed'({1'b0, meter_per_tic});
            end
            ddo_pkg::DP_MUL_ROT:
            begin
                mul_a = MW'(tic_diff);
                mul_b = signed'({1'b0, rot_per_tic});
            end
            ddo_pkg::DP_MUL_Y:
            begin
                mul_b = sin_v[MW-1:0];
            end
            default:
            begin
            end
        endcase
        prod_next = PW'(mul_a) * PW'(mul_b);
    end

    always_comb
    begin
        x_sh      = cx_reg >>> cmd.idx;
        y_sh      = cy_reg >>> cmd.idx;
        atan_v    = signed'({2'b00, ddo_pkg::atan_lookup(cmd.idx)});
        flip_init = head_reg[31] ^ head_reg[30];
        z_init    = CW'(signed'({head_reg[31] ^ flip_init, head_reg[30:0]}));
    end

    always_comb
    begin
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        head_next      = head_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (cmd.op)
            ddo_pkg::DP_COMMIT:
            begin
                pos_x_next     = pos_x_reg + dpx_reg;
                pos_y_next     = pos_y_reg + prod_reg[61:30];
                head_next      = head_reg + rot_reg;
                out_next       = '{dist_res: dist_reg, rot: rot_reg, pos_x: pos_x_next,
                                   pos_y: pos_y_next, heading: head_next};
                out_valid_next = 1'b1;
            end
            ddo_pkg::DP_SET:
            begin
                if (in_reg.set_mask[0])
                begin
                    pos_x_next = in_reg.new_x;
                end
                if (in_reg.set_mask[1])
                begin
                    pos_y_next = in_reg.new_y;
                end
                if (in_reg.set_mask[2])
                begin
                    head_next = in_reg.new_theta;
                end
                out_next       = '{dist_res: '0, rot: '0, pos_x: pos_x_next,
                                   pos_y: pos_y_next, heading: head_next};
                out_valid_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            head_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            head_reg      <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        case (cmd.op)
            ddo_pkg::DP_LOAD:
            begin
                in_reg <= in_item;
            end
            ddo_pkg::DP_MUL_DIST:
            begin
                prod_reg <= prod_next;
            end
            ddo_pkg::DP_MUL_ROT:
            begin
                dist_reg <= prod_reg[48:17];
                prod_reg <= prod_next;
            end
            ddo_pkg::DP_INIT:
            begin
                rot_reg  <= prod_reg[47:16];
                flip_reg <= flip_init;
                cx_reg   <= ddo_pkg::CORDIC_START;
                cy_reg   <= '0;
                cz_reg   <= z_init;
            end
            ddo_pkg::DP_ITER:
            begin
                if (!cz_reg[CW-1])
                begin
                    cx_reg <= cx_reg - y_sh;
                    cy_reg <= cy_reg + x_sh;
                    cz_reg <= cz_reg - atan_v;
                end
                else
                begin
                    cx_reg <= cx_reg + y_sh;
                    cy_reg <= cy_reg - x_sh;
                    cz_reg <= cz_reg + atan_v;
                end
            end
            ddo_pkg::DP_MUL_X:
            begin
                prod_reg <= prod_next;
            end
            ddo_pkg::DP_MUL_Y:
            begin
                dpx_reg  <= prod_reg[61:30];
                prod_reg <= prod_next;
            end
            default:
            begin
            end
        endcase
    end

    assign status.out_busy = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign out_item        = out_reg;

endmodule

FILE: sv/differential_drive_odometry.sv
// ----------------------------------------------------------------------------
// differential_drive_odometry
// Dead-reckoning pose tracker for a two-wheel robot with an APB register port.
// ----------------------------------------------------------------------------
// An odometry step runs, from acceptance to the result being offered, through
// two products on the one shared 33x33 multiplier for distance and heading change,
// a CORDIC set-up step, one CORDIC iteration per cycle for the sine and cosine
// of the old heading, two further products for the x and y increments, and a
// commit, which waits while the output register still holds an untaken result.
// A set item goes straight to the commit state. The next item is taken back in
// idle. Items are handled one at a time; a finished result waits in the output
// register while the next item runs.
// ----------------------------------------------------------------------------
module differential_drive_odometry #(
    parameter int SINCOS_STAGES = ddo_pkg::SINCOS_STAGES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  ddo_pkg::in_item_t           in_item,
    output logic                        out_valid,
    input  logic                        out_ready,
    output ddo_pkg::out_item_t          out_item,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ddo_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic [31:0]         meter_per_tic_reg;
    logic [31:0]         rot_per_tic_reg;
    logic                cfg_wr;
    ddo_pkg::dp_cmd_t    cmd;
    ddo_pkg::dp_status_t status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meter_per_tic_reg <= ddo_pkg::METER_PER_TIC_RST;
            rot_per_tic_reg   <= ddo_pkg::ROT_PER_TIC_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                ddo_pkg::REG_METER_PER_TIC: meter_per_tic_reg <= pwdata;
                ddo_pkg::REG_ROT_PER_TIC:   rot_per_tic_reg   <= pwdata;
                default:                    meter_per_tic_reg <= meter_per_tic_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            ddo_pkg::REG_METER_PER_TIC: prdata = meter_per_tic_reg;
            ddo_pkg::REG_ROT_PER_TIC:   prdata = rot_per_tic_reg;
            default:                    prdata = '0;
        endcase
    end

    ddo_ctrl #(
        .SINCOS_STAGES (SINCOS_STAGES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_opcode (in_item.opcode),
        .in_ready  (in_ready),
        .status    (status),
        .cmd       (cmd)
    );

    ddo_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .in_item       (in_item),
        .meter_per_tic (meter_per_tic_reg),
        .rot_per_tic   (rot_per_tic_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_item      (out_item)
    );

endmodule

FILE: verif/ddo_pose_checker.sv
// ----------------------------------------------------------------------------
// ddo_pose_checker
// Watches the item channels and the register port of the odometry block,
// tracks the scale registers as they are written, predicts each pose update
// (distance, heading change, CORDIC sine/cosine of the old heading, position
// increments) and compares every result, field by field, in order.
// ----------------------------------------------------------------------------
module ddo_pose_checker #(
    parameter int STAGES = ddo_pkg::SINCOS_STAGES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  ddo_pkg::in_item_t           in_item,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  ddo_pkg::out_item_t          out_item,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ddo_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    input  logic                        pready,
    output int                          fail_count,
    output int                          pending,
    output int                          results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ATAN_N = 30;
    localparam int PRINT_LIMIT = 20;
    localparam longint ATAN_TURNS [ATAN_N] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10680862, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1
    };

    logic [31:0]        meter_scale;
    logic [31:0]        turn_scale;
    logic [31:0]        x_pos;
    logic [31:0]        y_pos;
    logic [31:0]        theta;
    ddo_pkg::out_item_t expected_poses [$];
    ddo_pkg::out_item_t want;

    task automatic report_failure(input string msg);
        if (fail_count < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp_val);
        if (got !== exp_val)
            report_failure($sformatf("result %0d %s got %h want %h",
                                     results_checked, name, got, exp_val));
    endtask

    function automatic void heading_sincos(input logic [31:0] ang,
                                           output longint cos_q30,
                                           output longint sin_q30);
        logic [31:0] a;
        logic        flip;
        longint      cx;
        longint      sy;
        longint      z;
        longint      dx;
        longint      dy;
        int          i;
        a = ang;
        flip = a[31] ^ a[30];
        if (flip)
            a[31] = ~a[31];
        cx = longint'(ddo_pkg::CORDIC_START);
        sy = 0;
        z = longint'($signed(a));
        for (i = 0; i < STAGES && i < ATAN_N; i++)
        begin
            dx = sy >>> i;
            dy = cx >>> i;
            if (z >= 0)
            begin
                cx = cx - dx;
                sy = sy + dy;
                z = z - ATAN_TURNS[i];
            end
            else
            begin
                cx = cx + dx;
                sy = sy - dy;
                z = z + ATAN_TURNS[i];
            end
        end
        cos_q30 = flip ? -cx : cx;
        sin_q30 = flip ? -sy : sy;
    endfunction

    function automatic ddo_pkg::out_item_t advance_pose(input ddo_pkg::in_item_t it);
        ddo_pkg::out_item_t r;
        longint             tick_sum;
        longint             tick_diff;
        longint             step_len;
        longint             turn;
        longint             c;
        longint             s;
        r = '0;
        if (it.opcode == ddo_pkg::OP_SET)
        begin
            if (it.set_mask[0])
                x_pos = it.new_x;
            if (it.set_mask[1])
                y_pos = it.new_y;
            if (it.set_mask[2])
                theta = it.new_theta;
        end
        else
        begin
            tick_sum = longint'($signed(it.left_tics)) + longint'($signed(it.right_tics));
            tick_diff = longint'($signed(it.right_tics)) - longint'($signed(it.left_tics));
            step_len = (tick_sum * longint'(meter_scale)) >>> 17;
            turn = (tick_diff * longint'(turn_scale)) >>> 16;
            heading_sincos(theta, c, s);
            x_pos = x_pos + 32'((step_len * c) >>> 30);
            y_pos = y_pos + 32'((step_len * s) >>> 30);
            theta = theta + 32'(turn);
            r.dist_res = 32'(step_len);
            r.rot = 32'(turn);
        end
        r.pos_x = x_pos;
        r.pos_y = y_pos;
        r.heading = theta;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meter_scale = ddo_pkg::METER_PER_TIC_RST;
            turn_scale = ddo_pkg::ROT_PER_TIC_RST;
            x_pos = '0;
            y_pos = '0;
            theta = '0;
            expected_poses.delete();
            fail_count = 0;
            pending = 0;
            results_checked = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == {ddo_pkg::REG_METER_PER_TIC, 2'b00})
                    meter_scale = pwdata;
                else if (paddr == {ddo_pkg::REG_ROT_PER_TIC, 2'b00})
                    turn_scale = pwdata;
            end
            if (out_valid && out_ready)
            begin
                if (expected_poses.size() == 0)
                    report_failure($sformatf("result with no item pending: %h", out_item));
                else
                begin
                    want = expected_poses.pop_front();
                    check_field("dist_res", out_item.dist_res, want.dist_res);
                    check_field("rot", out_item.rot, want.rot);
                    check_field("pos_x", out_item.pos_x, want.pos_x);
                    check_field("pos_y", out_item.pos_y, want.pos_y);
                    check_field("heading", out_item.heading, want.heading);
                    results_checked++;
                end
            end
            if (in_valid && in_ready)
                expected_poses.push_back(advance_pose(in_item));
            pending = expected_poses.size();
        end
    end

endmodule

FILE: verif/tb_differential_drive_odometry.sv
// ----------------------------------------------------------------------------
// tb_differential_drive_odometry
// Stimulus and verdict for the odometry block: directed steps and pose loads
// at the tick and heading extremes, then random phases under changing scale
// registers, with random idling on both channels. Checking is in the checker.
// ----------------------------------------------------------------------------
module tb_differential_drive_odometry;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 600;
    localparam int PHASES       = 6;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = ddo_pkg::SINCOS_STAGES_DEF + 16;

    logic                        clk;
    logic                        rst_n     = 1'b0;
    logic                        in_valid  = 1'b0;
    logic                        in_ready;
    ddo_pkg::in_item_t           in_item   = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    ddo_pkg::out_item_t          out_item;
    logic                        psel      = 1'b0;
    logic                        penable   = 1'b0;
    logic                        pwrite    = 1'b0;
    logic [ddo_pkg::PADDR_W-1:0] paddr     = '0;
    logic [31:0]                 pwdata    = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    int fail_count;
    int pending;
    int results_checked;
    int items_sent     = 0;
    int directed_items = 0;
    int scale_settings = 1;
    int cycles         = 0;
    bit idle_on        = 1'b1;

    differential_drive_odometry i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_item (out_item),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    ddo_pose_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_item        (in_item),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_item       (out_item),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .fail_count     (fail_count),
        .pending        (pending),
        .results_checked(results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("FAIL differential_drive_odometry");
            $finish;
        end
    end

    always @(posedge clk)
        out_ready <= idle_on ? ($urandom_range(99) >= 27) : 1'b1;

    function automatic ddo_pkg::in_item_t random_item();
        ddo_pkg::in_item_t it;
        int                kind;
        kind = $urandom_range(99);
        it.opcode = (kind < 15) ? ddo_pkg::OP_SET : ddo_pkg::OP_STEP;
        it.new_x = $urandom;
        it.new_y = $urandom;
        it.new_theta = $urandom;
        it.set_mask = 3'($urandom);
        if (kind < 55)
        begin
            it.left_tics = 16'($urandom_range(511) - 256);
            it.right_tics = 16'($urandom_range(511) - 256);
        end
        else
        begin
            it.left_tics = 16'($urandom);
            it.right_tics = 16'($urandom);
        end
        if (kind >= 85)
            it.right_tics = it.left_tics;
        return it;
    endfunction

    function automatic ddo_pkg::in_item_t step_of(input logic [15:0] l,
                                                  input logic [15:0] r);
        ddo_pkg::in_item_t it;
        it = random_item();
        it.opcode = ddo_pkg::OP_STEP;
        it.left_tics = l;
        it.right_tics = r;
        return it;
    endfunction

    function automatic ddo_pkg::in_item_t set_of(input logic [2:0] mask,
                                                 input logic [31:0] x,
                                                 input logic [31:0] y,
                                                 input logic [31:0] th);
        ddo_pkg::in_item_t it;
        it = random_item();
        it.opcode = ddo_pkg::OP_SET;
        it.set_mask = mask;
        it.new_x = x;
        it.new_y = y;
        it.new_theta = th;
        return it;
    endfunction

    function automatic logic [31:0] random_scale();
        case ($urandom_range(4))
            0:       return 32'hFFFF_FFFF;
            1:       return 32'h0;
            2:       return 32'($urandom_range(1, 1 << 20));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input ddo_pkg::in_item_t it);
        if (idle_on && $urandom_range(99) < 27)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(3) == 0) ? 30 : 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        items_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_scales(input logic [31:0] meter_val, input logic [31:0] turn_val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {ddo_pkg::REG_METER_PER_TIC, 2'b00};
        pwdata <= meter_val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        paddr <= {ddo_pkg::REG_ROT_PER_TIC, 2'b00};
        pwdata <= turn_val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        scale_settings++;
    endtask

    initial
    begin
        int phase;
        int n;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(step_of(16'h0000, 16'h0000));
        send_item(step_of(16'h7FFF, 16'h7FFF));
        send_item(step_of(16'h8000, 16'h8000));
        send_item(step_of(16'h8000, 16'h7FFF));
        send_item(set_of(3'b111, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
        send_item(step_of(16'd1000, 16'd1000));
        send_item(set_of(3'b100, $urandom, $urandom, 32'h4000_0000));
        send_item(step_of(16'd1000, 16'd1000));
        send_item(set_of(3'b100, $urandom, $urandom, 32'hC000_0000));
        send_item(step_of(16'd1000, 16'd1000));
        send_item(set_of(3'b000, $urandom, $urandom, $urandom));
        send_item(set_of(3'b011, 32'h0, 32'h0, $urandom));
        drain();

        write_scales(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(step_of(16'h7FFF, 16'h8000));
        send_item(step_of(16'h8000, 16'h7FFF));
        send_item(step_of(16'h7FFF, 16'h7FFF));
        send_item(step_of(16'h8000, 16'h8000));
        send_item(set_of(3'b111, 32'h7FFF_0000, 32'h8001_0000, 32'h0));
        send_item(step_of(16'h7FFF, 16'h7FFF));
        send_item(step_of(16'h8000, 16'h8000));
        drain();

        // land the heading on exactly half a turn
        write_scales(32'h0, 32'h0001_0000);
        send_item(set_of(3'b100, $urandom, $urandom, 32'h7FFF_FFF0));
        send_item(step_of(16'hFFF8, 16'h0008));
        send_item(step_of(16'h0000, 16'h0000));
        directed_items = items_sent;
        drain();

        for (phase = 0; phase < PHASES; phase++)
        begin
            write_scales((phase == 0) ? ddo_pkg::METER_PER_TIC_RST : random_scale(),
                         (phase == 0) ? 32'($urandom_range(1, 1 << 16)) : random_scale());
            idle_on = (phase != 2);
            for (n = 0; n < RANDOM_ITEMS / PHASES; n++)
            begin
                send_item(random_item());
                if ($urandom_range(49) == 0)
                    drain();
            end
            drain();
        end

        idle_on = 1'b1;
        repeat (SETTLE) @(posedge clk);
        $display("%0d items sent (%0d directed), %0d results checked, %0d scale settings",
                 items_sent, directed_items, results_checked, scale_settings);
        $display("covered tick and scale extremes, half-turn wrap, masked pose loads");
        if (fail_count == 0)
            $display("PASS differential_drive_odometry");
        else
            $display("FAIL differential_drive_odometry");
        $finish;
    end

endmodule
